[design/ple_pkg.sv]
package ple_pkg;

  // Request codes carried on in_mode
  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_INSERT_AT  = 3'd2,
    MODE_GET        = 3'd3,
    MODE_CONTAINS   = 3'd4,
    MODE_FRONT      = 3'd5,
    MODE_LAST       = 3'd6,
    MODE_CLEAR      = 3'd7
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;
  localparam int LEN_W   = 7;

  // One finished result word, handed from the sequencer to the output stage
  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               found;
    status_t            status;
    logic [LEN_W-1:0]   length;
  } res_t;

endpackage

[design/positional_list_engine_top.sv]
// Positional list engine: an ordered list of up to ENTRIES values of DATA_W
// bits, front at index 0, held in one single-port-write, registered-read RAM.
// Request channel (in_valid/in_ready) carries mode, item_value and position;
// the result channel (out_valid/out_ready) returns one word per request with
// read_value, found, status and the length after the operation.
// One request is worked at a time; in_ready is high only while the sequencer
// is idle. An insert at index i below the length n (push front is i = 0)
// first moves entries n-1 down to i up one slot; contains scans from the front.
// The insert and search times are set by the single RAM read port, which
// moves or compares one entry per cycle. A result sits in the output
// register until taken; the next request is accepted meanwhile and its
// result waits in the sequencer while out_ready is low.
// Synchronous reset empties the list and drops any pending result; the RAM
// contents are not cleared and no reset pass is needed.
module positional_list_engine_top #(
  parameter int ENTRIES = 64,
  parameter int DATA_W  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_mode,
  input  logic [ple_pkg::VALUE_W-1:0] in_item_value,
  input  logic [ple_pkg::POS_W-1:0]   in_position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ple_pkg::VALUE_W-1:0] out_read_value,
  output logic                        out_found,
  output logic [1:0]                  out_status,
  output logic [ple_pkg::LEN_W-1:0]   out_length
);

  localparam int AW = $clog2(ENTRIES);

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic              res_valid;
  logic              res_ack;
  ple_pkg::res_t     res;
  logic              out_valid_r;
  ple_pkg::res_t     out_r;

  ple_seq #(
    .ENTRIES (ENTRIES),
    .DATA_W  (DATA_W)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_item_value (in_item_value),
    .in_position   (in_position),
    .res_valid     (res_valid),
    .res           (res),
    .res_ack       (res_ack),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  ple_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: loads when empty or being drained
  assign res_ack = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_r.read_value;
  assign out_found      = out_r.found;
  assign out_status     = out_r.status;
  assign out_length     = out_r.length;

endmodule

[design/ple_ram.sv]
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ple_seq.sv]
module ple_seq #(
  parameter int ENTRIES = 64,
  parameter int DATA_W  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request word
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_mode,
  input  logic [ple_pkg::VALUE_W-1:0] in_item_value,
  input  logic [ple_pkg::POS_W-1:0]   in_position,
  // finished result
  output logic                        res_valid,
  output ple_pkg::res_t               res,
  input  logic                        res_ack,
  // entry store port
  output logic                        ram_we,
  output logic [$clog2(ENTRIES)-1:0]  ram_waddr,
  output logic [DATA_W-1:0]           ram_wdata,
  output logic                        ram_re,
  output logic [$clog2(ENTRIES)-1:0]  ram_raddr,
  input  logic [DATA_W-1:0]           ram_rdata
);

  localparam int AW    = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SHIFT  = 6'b000010,
    S_PLACE  = 6'b000100,
    S_RDWAIT = 6'b001000,
    S_SEARCH = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         wa_r, wa_nxt;
  logic                  more_r, more_nxt;
  logic                  pend_r, pend_nxt;
  logic [DATA_W-1:0]     val_r, val_nxt;
  logic [DATA_W-1:0]     rv_r, rv_nxt;
  logic                  fnd_r, fnd_nxt;
  ple_pkg::status_t      st_r, st_nxt;

  logic [63:0]           item_ext;
  logic [63:0]           rv_ext;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      ins_idx;
  logic [AW-1:0]         last_addr;
  ple_pkg::mode_t        mode;

  // Operand alignment
  assign item_ext  = 64'(in_item_value);
  assign rv_ext    = 64'(rv_r);
  assign pos_ext   = CMP_W'(in_position);
  assign cnt_ext   = CMP_W'(count_r);
  assign last_addr = AW'(count_r - CNT_W'(1));
  assign mode      = ple_pkg::mode_t'(in_mode);

  always_comb begin
    case (mode)
      ple_pkg::MODE_PUSH_FRONT: ins_idx = '0;
      ple_pkg::MODE_PUSH_BACK:  ins_idx = cnt_ext;
      default:                  ins_idx = pos_ext;
    endcase
  end

  // Result handed to the output stage
  assign res_valid      = (state_r == S_RESP);
  assign res.read_value = rv_ext[ple_pkg::VALUE_W-1:0];
  assign res.found      = fnd_r;
  assign res.status     = st_r;
  assign res.length     = ple_pkg::LEN_W'(count_r);
  assign in_ready       = (state_r == S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    idx_nxt   = idx_r;
    wa_nxt    = wa_r;
    more_nxt  = more_r;
    pend_nxt  = pend_r;
    val_nxt   = val_r;
    rv_nxt    = rv_r;
    fnd_nxt   = fnd_r;
    st_nxt    = st_r;
    ram_we    = 1'b0;
    ram_waddr = wa_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt = item_ext[DATA_W-1:0];
          rv_nxt  = '0;
          fnd_nxt = 1'b0;
          st_nxt  = ple_pkg::ST_OK;
          unique case (mode) inside
            ple_pkg::MODE_PUSH_FRONT, ple_pkg::MODE_PUSH_BACK,
            ple_pkg::MODE_INSERT_AT: begin
              if (mode == ple_pkg::MODE_INSERT_AT && pos_ext > cnt_ext) begin
                st_nxt    = ple_pkg::ST_RANGE;
                state_nxt = S_RESP;
              end else if (cnt_ext == CMP_W'(ENTRIES)) begin
                st_nxt    = ple_pkg::ST_FULL;
                state_nxt = S_RESP;
              end else begin
                idx_nxt = AW'(ins_idx);
                if (ins_idx < cnt_ext) begin
                  // later entries move up one slot, last one first
                  ptr_nxt   = last_addr;
                  more_nxt  = 1'b1;
                  pend_nxt  = 1'b0;
                  state_nxt = S_SHIFT;
                end else begin
                  state_nxt = S_PLACE;
                end
              end
            end
            ple_pkg::MODE_GET: begin
              if (pos_ext >= cnt_ext) begin
                st_nxt    = ple_pkg::ST_RANGE;
                state_nxt = S_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_position);
                state_nxt = S_RDWAIT;
              end
            end
            ple_pkg::MODE_FRONT, ple_pkg::MODE_LAST: begin
              if (count_r == '0) begin
                st_nxt    = ple_pkg::ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = (mode == ple_pkg::MODE_FRONT) ? '0 : last_addr;
                state_nxt = S_RDWAIT;
              end
            end
            ple_pkg::MODE_CONTAINS: begin
              if (count_r == '0) begin
                state_nxt = S_RESP;
              end else begin
                ptr_nxt   = '0;
                more_nxt  = 1'b1;
                pend_nxt  = 1'b0;
                state_nxt = S_SEARCH;
              end
            end
            ple_pkg::MODE_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      // read entry ptr while writing the previous read one slot higher
      S_SHIFT: begin
        ram_we    = pend_r;
        ram_waddr = wa_r;
        ram_wdata = ram_rdata;
        if (more_r) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_r;
          wa_nxt    = ptr_r + AW'(1);
          pend_nxt  = 1'b1;
          more_nxt  = (ptr_r != idx_r);
          ptr_nxt   = ptr_r - AW'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_PLACE;
        end
      end

      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = val_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_RESP;
      end

      S_RDWAIT: begin
        rv_nxt    = ram_rdata;
        state_nxt = S_RESP;
      end

      // scan from the front, one entry per cycle, stop at the first match
      S_SEARCH: begin
        if (pend_r && ram_rdata == val_r) begin
          fnd_nxt   = 1'b1;
          state_nxt = S_RESP;
        end else if (more_r) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_r;
          pend_nxt  = 1'b1;
          more_nxt  = (ptr_r != last_addr);
          ptr_nxt   = ptr_r + AW'(1);
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      more_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      more_r  <= more_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    idx_r <= idx_nxt;
    wa_r  <= wa_nxt;
    val_r <= val_nxt;
    rv_r  <= rv_nxt;
    fnd_r <= fnd_nxt;
    st_r  <= st_nxt;
  end

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES      = 64;
  localparam int RANDOM_ITEMS = 1900;
  localparam int LIMIT        = 1000000;
  localparam int CALM_TAIL    = 150;
  localparam int LONG_HOLD    = 600;
  localparam int VALUE_W      = ple_pkg::VALUE_W;
  localparam int POS_W        = ple_pkg::POS_W;
  localparam int LEN_W        = ple_pkg::LEN_W;

  // one request word waiting to be offered; drain holds it back until the block is empty
  typedef struct {
    ple_pkg::mode_t    mode;
    logic [31:0]       value;
    logic [POS_W-1:0]  pos;
    bit                drain;
  } req_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [2:0]          in_mode = ple_pkg::MODE_CLEAR;
  logic [VALUE_W-1:0]  in_item_value = '0;
  logic [POS_W-1:0]    in_position = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [VALUE_W-1:0]  out_read_value;
  logic                out_found;
  logic [1:0]          out_status;
  logic [LEN_W-1:0]    out_length;

  positional_list_engine_top #(
    .ENTRIES(ENTRIES),
    .DATA_W (32)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_item_value (in_item_value),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_value(out_read_value),
    .out_found     (out_found),
    .out_status    (out_status),
    .out_length    (out_length)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  req_word_t          request_backlog[$];
  ple_pkg::res_t      replies[$];
  int                 plan_len = 0;
  bit                 hold_next = 1'b0;
  int                 taken_count = 0;
  int                 results_seen = 0;
  int                 errors = 0;
  bit                 word_taken = 1'b0;
  int                 send_gap = 0;
  int                 stall_left = 0;
  bit                 long_hold_done = 1'b0;

  // no idling once the backlog runs short
  function automatic bit calm();
    return (request_backlog.size() < CALM_TAIL);
  endfunction

  // list mirror used for prediction
  logic [31:0] list_mem [ENTRIES];
  int          list_len = 0;

  function automatic ple_pkg::status_t place_entry(logic [31:0] v, int idx);
    if (list_len >= ENTRIES) return ple_pkg::ST_FULL;
    for (int k = list_len; k > idx; k--) list_mem[k] = list_mem[k-1];
    list_mem[idx] = v;
    list_len++;
    return ple_pkg::ST_OK;
  endfunction

  // apply one request to the mirror and return the word the block should send
  function automatic ple_pkg::res_t list_apply(ple_pkg::mode_t m, logic [31:0] v,
                                               logic [POS_W-1:0] p);
    ple_pkg::res_t r;
    r = '0;
    r.status = ple_pkg::ST_OK;
    case (m)
      ple_pkg::MODE_PUSH_FRONT: r.status = place_entry(v, 0);
      ple_pkg::MODE_PUSH_BACK:  r.status = place_entry(v, list_len);
      ple_pkg::MODE_INSERT_AT: begin
        if (int'(p) > list_len) r.status = ple_pkg::ST_RANGE;
        else r.status = place_entry(v, int'(p));
      end
      ple_pkg::MODE_GET: begin
        if (int'(p) >= list_len) r.status = ple_pkg::ST_RANGE;
        else r.read_value = list_mem[p];
      end
      ple_pkg::MODE_CONTAINS: begin
        for (int k = 0; k < list_len; k++) begin
          if (list_mem[k] == v) r.found = 1'b1;
        end
      end
      ple_pkg::MODE_FRONT: begin
        if (list_len == 0) r.status = ple_pkg::ST_EMPTY;
        else r.read_value = list_mem[0];
      end
      ple_pkg::MODE_LAST: begin
        if (list_len == 0) r.status = ple_pkg::ST_EMPTY;
        else r.read_value = list_mem[list_len-1];
      end
      default: list_len = 0;
    endcase
    r.length = LEN_W'(list_len);
    return r;
  endfunction

  // append a request to the backlog, tracking the list length it will leave behind
  task automatic queue_request(ple_pkg::mode_t m, logic [31:0] v, logic [POS_W-1:0] p);
    req_word_t w;
    w.mode  = m;
    w.value = v;
    w.pos   = p;
    w.drain = hold_next;
    hold_next = 1'b0;
    request_backlog.insert(request_backlog.size(), w);
    case (m)
      ple_pkg::MODE_PUSH_FRONT, ple_pkg::MODE_PUSH_BACK: if (plan_len < ENTRIES) plan_len++;
      ple_pkg::MODE_INSERT_AT: if (int'(p) <= plan_len && plan_len < ENTRIES) plan_len++;
      ple_pkg::MODE_CLEAR: plan_len = 0;
      default: ;
    endcase
  endtask

  // random request; grow_only restricts it to the three inserting modes
  task automatic queue_random_op(bit grow_only);
    int               r;
    ple_pkg::mode_t   m;
    logic [31:0]      v;
    logic [POS_W-1:0] p;
    r = grow_only ? $urandom_range(0, 44) : $urandom_range(0, 99);
    if (r < 15)      m = ple_pkg::MODE_PUSH_FRONT;
    else if (r < 30) m = ple_pkg::MODE_PUSH_BACK;
    else if (r < 45) m = ple_pkg::MODE_INSERT_AT;
    else if (r < 65) m = ple_pkg::MODE_GET;
    else if (r < 80) m = ple_pkg::MODE_CONTAINS;
    else if (r < 89) m = ple_pkg::MODE_FRONT;
    else if (r < 98) m = ple_pkg::MODE_LAST;
    else             m = ple_pkg::MODE_CLEAR;
    // small pool so contains hits often, plus extremes and full-width noise
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 15);
      4:          v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default:    v = $urandom;
    endcase
    if ($urandom_range(0, 99) < 85) begin
      if (m == ple_pkg::MODE_GET) p = POS_W'($urandom_range(0, plan_len > 0 ? plan_len - 1 : 0));
      else                        p = POS_W'($urandom_range(0, plan_len));
    end else begin
      p = POS_W'($urandom_range(0, 127));
    end
    queue_request(m, v, p);
  endtask

  // accept side: predict on input words, check on output words
  always @(posedge clk) begin : accept_words
    ple_pkg::res_t want;
    ple_pkg::res_t next_word;
    if (rst_n && in_valid && in_ready) begin
      next_word = list_apply(ple_pkg::mode_t'(in_mode), in_item_value, in_position);
      replies.insert(replies.size(), next_word);
      taken_count++;
      word_taken = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (replies.size() == 0) begin
        $display("%0t: unexpected result word: value %h found %b status %0d length %0d",
                 $time, out_read_value, out_found, out_status, out_length);
        errors++;
      end else begin
        want = replies[0];
        replies.delete(0);
        if (out_read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                   out_read_value);
          errors++;
        end
        if (out_found !== want.found) begin
          $display("%0t: found expected %b actual %b", $time, want.found, out_found);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_length !== want.length) begin
          $display("%0t: length expected %0d actual %0d", $time, want.length, out_length);
          errors++;
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin : drive_requests
    req_word_t w;
    if (rst_n && !(in_valid && !word_taken)) begin
      word_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (request_backlog.size() == 0) begin
        in_valid <= 1'b0;
      end else if (request_backlog[0].drain && replies.size() != 0) begin
        in_valid <= 1'b0;
      end else if (!calm() && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 9) - 1;
        in_valid <= 1'b0;
      end else begin
        w = request_backlog[0];
        request_backlog.delete(0);
        in_valid      <= 1'b1;
        in_mode       <= w.mode;
        in_item_value <= w.value;
        in_position   <= w.pos;
      end
    end
  end

  // result receiver: random stalls plus one long hold-off
  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 400) begin
      long_hold_done = 1'b1;
      stall_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (!calm() && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : timeout
    repeat (LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int total;
    int goal;

    // directed: empty list cases first
    queue_request(ple_pkg::MODE_FRONT, 32'h0, 7'd0);
    queue_request(ple_pkg::MODE_LAST, 32'h0, 7'd0);
    queue_request(ple_pkg::MODE_GET, 32'h0, 7'd0);
    queue_request(ple_pkg::MODE_CONTAINS, 32'h0, 7'd0);
    queue_request(ple_pkg::MODE_INSERT_AT, 32'h1234_5678, 7'd1);
    // build a short list through every insert path
    queue_request(ple_pkg::MODE_INSERT_AT, 32'hFFFF_FFFF, 7'd0);
    queue_request(ple_pkg::MODE_PUSH_BACK, 32'h0000_0000, 7'd0);
    queue_request(ple_pkg::MODE_PUSH_FRONT, 32'h8000_0001, 7'd127);
    queue_request(ple_pkg::MODE_INSERT_AT, 32'hA5A5_A5A5, 7'd3);
    queue_request(ple_pkg::MODE_INSERT_AT, 32'h5A5A_5A5A, 7'd1);
    queue_request(ple_pkg::MODE_INSERT_AT, 32'h0, 7'd127);
    queue_request(ple_pkg::MODE_INSERT_AT, 32'h0, 7'd64);
    // reads in and out of range
    queue_request(ple_pkg::MODE_GET, 32'hFFFF_FFFF, 7'd0);
    queue_request(ple_pkg::MODE_GET, 32'h0, 7'd4);
    queue_request(ple_pkg::MODE_GET, 32'h0, 7'd5);
    queue_request(ple_pkg::MODE_GET, 32'h0, 7'd127);
    queue_request(ple_pkg::MODE_CONTAINS, 32'hFFFF_FFFF, 7'd0);
    queue_request(ple_pkg::MODE_CONTAINS, 32'h1234_5678, 7'd0);
    queue_request(ple_pkg::MODE_CONTAINS, 32'hA5A5_A5A5, 7'd0);
    queue_request(ple_pkg::MODE_FRONT, 32'h0, 7'd0);
    queue_request(ple_pkg::MODE_LAST, 32'h0, 7'd0);
    queue_request(ple_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 7'd127);
    queue_request(ple_pkg::MODE_LAST, 32'h0, 7'd0);
    queue_request(ple_pkg::MODE_CONTAINS, 32'hFFFF_FFFF, 7'd0);

    // random episodes: some fill the list to the top and poke at it, others mix freely
    hold_next = 1'b1;
    goal = request_backlog.size() + RANDOM_ITEMS;
    while (request_backlog.size() < goal) begin
      if ($urandom_range(0, 7) == 0) hold_next = 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        while (plan_len < ENTRIES) queue_random_op(1'b1);
        repeat ($urandom_range(5, 20)) queue_random_op(1'b0);
      end else begin
        repeat ($urandom_range(10, 60)) queue_random_op(1'b0);
      end
      if ($urandom_range(0, 1) == 0) queue_request(ple_pkg::MODE_CLEAR, $urandom, 7'($urandom));
    end
    total = request_backlog.size();

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (taken_count < total || replies.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
